// File: rtl/pnm_hdr_pkg.sv
// Shared types, character codes and helpers for the PNM header parser.
package pnm_hdr_pkg;

   localparam int NUMBER_BITS = 31;   // header number register width, 8..31
   localparam int DIM_BITS = 31;      // width of the reported image dimensions

   localparam logic [NUMBER_BITS-1:0] NUM_MASK = '1;
   localparam logic [NUMBER_BITS-1:0] NUM_LIMIT =
      (NUM_MASK - NUMBER_BITS'(9)) / NUMBER_BITS'(10);
   localparam logic [NUMBER_BITS-1:0] MAXVAL_LIMIT = NUMBER_BITS'(255);
   localparam logic [NUMBER_BITS-1:0] DECIMAL_BASE = NUMBER_BITS'(10);

   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_P       = 8'h50;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_FIVE    = 8'h35;
   localparam logic [7:0] CH_SIX     = 8'h36;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [1:0] {
      ST_HEADER = 2'd0,
      ST_PIXEL  = 2'd1,
      ST_FAILED = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_NOT_PNM = 3'd1,
      ERR_FORMAT  = 3'd2,
      ERR_HEADER  = 3'd3,
      ERR_MAXVAL  = 3'd4,
      ERR_TRUNC   = 3'd5
   } error_type;

   typedef struct packed {
      status_type          status;
      logic [7:0]          pixel_byte;
      logic                last_pixel;
      error_type           error_code;
      logic [DIM_BITS-1:0] image_width;
      logic [DIM_BITS-1:0] image_height;
      logic [1:0]          channel_count;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

// File: rtl/pnm_header_parser.sv
// Binary PNM (P5/P6) header parser: checks and decodes the header, then passes the image bytes.
// Takes one file byte per clock while req_stall is low and returns one registered result per byte.
// Every item is handled in a single pass of short logic from the parser state to a result
// register; a one-entry skid stage behind that register lets req_stall come straight from a
// flop, so a new item is taken each cycle as long as results are drained. The image byte
// count is tracked by channel, column and row counters rather than a width*height product;
// the last pixel is flagged when all three reach their ends. Failures are sticky until an
// item with start_of_file. No clearing pass or warm-up after reset.
module pnm_header_parser
   import pnm_hdr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_start_of_file,
   input  logic                req_end_of_stream,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_pixel_byte,
   output logic                rsp_last_pixel,
   output logic [2:0]          rsp_error_code,
   output logic [DIM_BITS-1:0] rsp_image_width,
   output logic [DIM_BITS-1:0] rsp_image_height,
   output logic [1:0]          rsp_channel_count
);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_FORMAT,
      PH_SEP,
      PH_FIELD,
      PH_DATA,
      PH_DONE,
      PH_FAILED
   } phase_type;

   phase_type              phase_ff, phase_in, phase_cur;
   logic                   comment_ff, comment_in, comment_cur;
   logic                   five_ff, five_in, five_cur;      // format is '5'
   logic                   fmt_ok_ff, fmt_ok_in, fmt_ok_cur; // format is '5' or '6'
   logic [1:0]             field_ff, field_in, field_cur;
   logic                   seen_ff, seen_in, seen_cur;
   logic [NUMBER_BITS-1:0] num_ff, num_in;
   logic [NUMBER_BITS-1:0] width_ff, width_in;
   logic [NUMBER_BITS-1:0] height_ff, height_in;
   logic [1:0]             chan_ff, chan_in;
   logic [NUMBER_BITS-1:0] col_ff, col_in;
   logic [NUMBER_BITS-1:0] row_ff, row_in;
   error_type              err_ff, err_in;

   result_type             out_ff, skid_ff, result;
   logic                   out_valid_ff, skid_valid_ff;

   logic                   accept, take;
   logic                   last;
   logic                   pixel;
   logic                   hdr_done;
   logic [1:0]             chan_max;
   logic [7:0]             c;
   logic [NUMBER_BITS-1:0] digit_val;

   assign accept = req_valid && !req_stall;
   assign take = out_valid_ff && !rsp_stall;
   assign c = req_data_byte;
   assign digit_val = NUMBER_BITS'(c - CH_ZERO);

   always_comb begin
      // start_of_file behaves as a reset applied just before this byte
      phase_cur   = req_start_of_file ? PH_MAGIC : phase_ff;
      comment_cur = req_start_of_file ? 1'b0 : comment_ff;
      five_cur    = req_start_of_file ? 1'b0 : five_ff;
      fmt_ok_cur  = req_start_of_file ? 1'b0 : fmt_ok_ff;
      field_cur   = req_start_of_file ? 2'd0 : field_ff;
      seen_cur    = req_start_of_file ? 1'b0 : seen_ff;

      phase_in   = phase_cur;
      comment_in = comment_cur;
      five_in    = five_cur;
      fmt_ok_in  = fmt_ok_cur;
      field_in   = field_cur;
      seen_in    = seen_cur;
      num_in     = num_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      chan_in    = chan_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      err_in     = err_ff;
      last       = 1'b0;
      pixel      = 1'b0;
      chan_max   = five_cur ? 2'd0 : 2'd2;

      if (phase_cur == PH_DATA) begin
         if (req_end_of_stream) begin
            phase_in = PH_FAILED;
            err_in = ERR_TRUNC;
         end else begin
            pixel = 1'b1;
            if (chan_ff == chan_max) begin
               chan_in = 2'd0;
               if (col_ff == width_ff - NUMBER_BITS'(1)) begin
                  col_in = '0;
                  row_in = row_ff + NUMBER_BITS'(1);
                  if (row_ff == height_ff - NUMBER_BITS'(1)) begin
                     last = 1'b1;
                     phase_in = PH_DONE;
                  end
               end else begin
                  col_in = col_ff + NUMBER_BITS'(1);
               end
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
      end else if (phase_cur == PH_DONE || phase_cur == PH_FAILED) begin
         // sticky
      end else if (phase_cur == PH_FORMAT) begin
         if (!req_end_of_stream && c >= CH_ONE && c <= CH_SIX) begin
            five_in = (c == CH_FIVE);
            fmt_ok_in = (c == CH_FIVE) || (c == CH_SIX);
            phase_in = PH_SEP;
         end else begin
            phase_in = PH_FAILED;
            err_in = ERR_NOT_PNM;
         end
      end else if (req_end_of_stream) begin
         phase_in = PH_FAILED;
         err_in = (phase_cur == PH_FIELD) ? ERR_HEADER : ERR_NOT_PNM;
      end else if (comment_cur) begin
         if (c == CH_NEWLINE) begin
            comment_in = 1'b0;
         end
      end else if (c == CH_HASH) begin
         comment_in = 1'b1;
      end else if (phase_cur == PH_MAGIC) begin
         if (c == CH_P) begin
            phase_in = PH_FORMAT;
         end else begin
            phase_in = PH_FAILED;
            err_in = ERR_NOT_PNM;
         end
      end else if (phase_cur == PH_SEP) begin
         if (!is_space(c)) begin
            phase_in = PH_FAILED;
            err_in = ERR_NOT_PNM;
         end else if (!fmt_ok_cur) begin
            phase_in = PH_FAILED;
            err_in = ERR_FORMAT;
         end else begin
            phase_in = PH_FIELD;
         end
      end else if (!seen_cur) begin
         if (is_digit(c)) begin
            seen_in = 1'b1;
            num_in = digit_val;
         end else if (!is_space(c)) begin
            phase_in = PH_FAILED;
            err_in = ERR_HEADER;
         end
      end else if (is_digit(c)) begin
         if (num_ff > NUM_LIMIT) begin
            phase_in = PH_FAILED;
            err_in = ERR_HEADER;
         end else begin
            num_in = NUMBER_BITS'(num_ff * DECIMAL_BASE) + digit_val;
         end
      end else if (!is_space(c)) begin
         phase_in = PH_FAILED;
         err_in = ERR_HEADER;
      end else if (field_cur == 2'd2) begin
         // maxval complete: header ends here
         if (num_ff > MAXVAL_LIMIT) begin
            phase_in = PH_FAILED;
            err_in = ERR_MAXVAL;
         end else if (width_ff == '0 || height_ff == '0) begin
            phase_in = PH_FAILED;
            err_in = ERR_TRUNC;
         end else begin
            phase_in = PH_DATA;
            chan_in = 2'd0;
            col_in = '0;
            row_in = '0;
         end
      end else begin
         if (field_cur == 2'd0) begin
            width_in = num_ff;
         end else begin
            height_in = num_ff;
         end
         field_in = field_cur + 2'd1;
         num_in = '0;
         seen_in = 1'b0;
      end

      hdr_done = (phase_in == PH_DATA) || (phase_in == PH_DONE) ||
                 (phase_in == PH_FAILED && err_in == ERR_TRUNC);

      if (phase_in == PH_FAILED) begin
         result.status = ST_FAILED;
      end else if (phase_in == PH_DONE && !last) begin
         result.status = ST_DONE;
      end else if (pixel) begin
         result.status = ST_PIXEL;
      end else begin
         result.status = ST_HEADER;
      end
      result.pixel_byte    = pixel ? c : 8'd0;
      result.last_pixel    = last;
      result.error_code    = (phase_in == PH_FAILED) ? err_in : ERR_NONE;
      result.image_width   = hdr_done ? DIM_BITS'(width_in) : '0;
      result.image_height  = hdr_done ? DIM_BITS'(height_in) : '0;
      result.channel_count = five_in ? 2'd1 : 2'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         comment_ff    <= 1'b0;
         five_ff       <= 1'b0;
         fmt_ok_ff     <= 1'b0;
         field_ff      <= 2'd0;
         seen_ff       <= 1'b0;
         err_ff        <= ERR_NONE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            comment_ff <= comment_in;
            five_ff    <= five_in;
            fmt_ok_ff  <= fmt_ok_in;
            field_ff   <= field_in;
            seen_ff    <= seen_in;
            err_ff     <= err_in;
         end
         // skid holds an item only while the output register is full
         if (skid_valid_ff) begin
            if (take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         num_ff    <= num_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_pixel_byte    = out_ff.pixel_byte;
   assign rsp_last_pixel    = out_ff.last_pixel;
   assign rsp_error_code    = out_ff.error_code;
   assign rsp_image_width   = out_ff.image_width;
   assign rsp_image_height  = out_ff.image_height;
   assign rsp_channel_count = out_ff.channel_count;

endmodule
